// ===== sv/cla_pkg.sv =====
package cla_pkg;

    localparam int LINE_BUFFER_BYTES = 64;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_NUL = 8'h00;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic take;
        logic rd_en;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic term;
        logic line_empty;
        logic rd_was_last;
        logic out_free;
    } status_t;

endpackage

// ===== sv/cla_ram.sv =====
module cla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/cla_ctrl.sv =====
module cla_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  cla_pkg::status_t status,
    output cla_pkg::cmd_t    cmd
);

    cla_pkg::state_t state_reg;
    cla_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cla_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cla_pkg::ST_IDLE:
            begin
                if (in_valid && status.term && !status.line_empty)
                begin
                    state_next = cla_pkg::ST_FETCH;
                end
            end
            cla_pkg::ST_FETCH:
            begin
                state_next = cla_pkg::ST_LOAD;
            end
            cla_pkg::ST_LOAD:
            begin
                if (status.out_free)
                begin
                    state_next = status.rd_was_last ? cla_pkg::ST_IDLE : cla_pkg::ST_FETCH;
                end
            end
            default:
            begin
                state_next = cla_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd.take     = 1'b0;
        cmd.rd_en    = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            cla_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            cla_pkg::ST_FETCH:
            begin
                cmd.rd_en = 1'b1;
            end
            cla_pkg::ST_LOAD:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== sv/cla_dp.sv =====
module cla_dp #(
    parameter int LINE_BUFFER_BYTES = cla_pkg::LINE_BUFFER_BYTES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        rx_byte,
    input  cla_pkg::cmd_t     cmd,
    output cla_pkg::status_t  status,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        line_byte,
    output logic              last_of_line,
    output logic              line_truncated
);

    localparam int AW = $clog2(LINE_BUFFER_BYTES);
    localparam logic [AW-1:0] LIMIT = AW'(LINE_BUFFER_BYTES - 1);

    logic [AW-1:0] count_reg;
    logic [AW-1:0] last_idx_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic          ovf_reg;
    logic          trunc_reg;
    logic          rd_last_reg;
    logic          out_valid_reg;
    logic [7:0]    line_byte_reg;
    logic          last_reg;
    logic          out_trunc_reg;

    logic          term;
    logic          full;
    logic          wr_en;
    logic [7:0]    rdata;

    assign term  = rx_byte inside {cla_pkg::CH_CR, cla_pkg::CH_LF, cla_pkg::CH_NUL};
    assign full  = (count_reg == LIMIT);
    assign wr_en = cmd.take && !term && !full;

    cla_ram #(
        .WIDTH (8),
        .DEPTH (LINE_BUFFER_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg),
        .wdata (rx_byte),
        .re    (cmd.rd_en),
        .raddr (rd_ptr_reg),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                if (term)
                begin
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                end
                else if (full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && term)
        begin
            last_idx_reg <= count_reg - 1'b1;
            trunc_reg    <= ovf_reg;
            rd_ptr_reg   <= '0;
        end
        else if (cmd.rd_en)
        begin
            rd_last_reg <= (rd_ptr_reg == last_idx_reg);
            rd_ptr_reg  <= rd_ptr_reg + 1'b1;
        end
        if (cmd.load_out)
        begin
            line_byte_reg <= rdata;
            last_reg      <= rd_last_reg;
            out_trunc_reg <= trunc_reg;
        end
    end

    assign status.term        = term;
    assign status.line_empty  = (count_reg == '0);
    assign status.rd_was_last = rd_last_reg;
    assign status.out_free    = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign line_byte      = line_byte_reg;
    assign last_of_line   = last_reg;
    assign line_truncated = out_trunc_reg;

endmodule

// ===== sv/crlf_line_assembler_core.sv =====
// After a terminator is taken, the line's first byte is read from the store.
// Readout: per stored byte, one store read (FETCH) plus an output load (LOAD)
// that waits for a free output; input is held off while a line is read out.
// Throughput: one input item per cycle outside readout.
// Reset (rst_n, async, active low) clears state, count, flag and output valid;
// the line store keeps its contents and needs no clearing pass.
module crlf_line_assembler_core #(
    parameter int LINE_BUFFER_BYTES = cla_pkg::LINE_BUFFER_BYTES
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] line_byte,
    output logic       last_of_line,
    output logic       line_truncated
);

    cla_pkg::cmd_t    cmd;
    cla_pkg::status_t status;

    cla_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    cla_dp #(
        .LINE_BUFFER_BYTES (LINE_BUFFER_BYTES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx_byte        (rx_byte),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .line_byte      (line_byte),
        .last_of_line   (last_of_line),
        .line_truncated (line_truncated)
    );

endmodule
